[sv/sme_pkg.sv]
// Shared types, codes and sizes for the substring match engine.
// No dependencies; imported by every module of the block.
`default_nettype none
package sme_pkg;

    localparam int PATTERN_MAX    = 16;
    localparam int PAT_IDX_W      = $clog2(PATTERN_MAX);
    localparam int PAT_LEN_W      = $clog2(PATTERN_MAX + 1);
    localparam int TEXT_ADDR_BITS = 16;
    localparam int POS_W          = TEXT_ADDR_BITS + 1;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_IDX_W      = 2;

    // operation codes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_TEXT   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    // result status codes
    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;

    // match modes
    localparam logic [1:0] MODE_FIND   = 2'd0;
    localparam logic [1:0] MODE_STARTS = 2'd1;
    localparam logic [1:0] MODE_ENDS   = 2'd2;
    localparam logic [1:0] MODE_EQUALS = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CASE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MODE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_START   = 2'd3;

    typedef logic [PATTERN_MAX-1:0][7:0] window_t;

    typedef struct packed {
        logic [1:0]           operation;
        logic [7:0]           data_byte;
        logic [PAT_IDX_W-1:0] pattern_slot;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [TEXT_ADDR_BITS-1:0] match_offset;
        logic [PAT_LEN_W-1:0]      match_length;
    } out_item_t;

    typedef struct packed {
        logic [PAT_LEN_W-1:0]      pattern_length;
        logic                      ignore_case;
        logic [1:0]                match_mode;
        logic [TEXT_ADDR_BITS-1:0] search_start;
    } cfg_t;

endpackage
`default_nettype wire

[sv/substring_match_engine_top.sv]
// Top level of the substring match engine: input and result registers,
// configuration registers, handshake. Depends on sme_pkg and sme_core.
//
// Pattern bytes, text bytes and finish transactions are taken at one per
// clock cycle. A transaction passes an input register, then the 16-byte
// parallel window compare and the match state update, and a finish lands in
// the result register: m_valid rises when the finish is written there.
// The input side stalls only when a finish meets a result register that
// holds an untaken result. Load, text and unknown transactions give no result.
`default_nettype none
module substring_match_engine_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  sme_pkg::in_item_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output sme_pkg::out_item_t                 m_data,
    input  logic                               cfg_we,
    input  logic [sme_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sme_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import sme_pkg::*;

    in_item_t  in_reg;
    logic      in_vld_reg;
    out_item_t out_reg;
    logic      m_vld_reg;
    cfg_t      cfg_reg;
    out_item_t result;
    logic      is_finish;
    logic      stall;
    logic      fire;

    assign is_finish = in_vld_reg && (in_reg.operation == OP_FINISH);
    assign stall     = is_finish && m_vld_reg && !m_ready;
    assign fire      = in_vld_reg && !stall;
    assign s_ready   = !in_vld_reg || fire;
    assign m_valid   = m_vld_reg;
    assign m_data    = out_reg;

    sme_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (fire && is_finish) begin
            m_vld_reg <= 1'b1;
        end else if (m_ready) begin
            m_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && is_finish) begin
            out_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PATTERN_LENGTH: cfg_reg.pattern_length <= cfg_wdata[PAT_LEN_W-1:0];
                CFG_IGNORE_CASE:    cfg_reg.ignore_case    <= cfg_wdata[0];
                CFG_MATCH_MODE:     cfg_reg.match_mode     <= cfg_wdata[1:0];
                CFG_SEARCH_START:   cfg_reg.search_start   <= cfg_wdata[TEXT_ADDR_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && m_vld_reg && !m_ready))
        else $error("input stalled without a blocked result");

    a_finish_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && is_finish) |=> m_valid)
        else $error("finish transaction produced no result");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != ST_FOUND) |->
        (m_data.match_offset == '0 && m_data.match_length == '0))
        else $error("non-found result carries offset or length");

    a_found_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_FOUND) |->
        (m_data.match_length != '0 &&
         m_data.match_length <= PAT_LEN_W'(PATTERN_MAX)))
        else $error("found result with bad length");

endmodule
`default_nettype wire

[sv/sme_win_cmp.sv]
// Parallel compare of the text window against the pattern store.
// Depends on sme_pkg.
`default_nettype none
module sme_win_cmp (
    input  sme_pkg::window_t                  window,
    input  sme_pkg::window_t                  pattern,
    input  logic [sme_pkg::PAT_LEN_W-1:0]     len,
    input  logic                              ignore_case,
    output logic                              hit
);
    import sme_pkg::*;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
        if (ic && c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    logic [PATTERN_MAX-1:0] ok;

    // pattern byte k lines up with window entry len-1-k
    always_comb begin
        logic [PAT_LEN_W-1:0] d;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            d = len - PAT_LEN_W'(k) - PAT_LEN_W'(1);
            if (PAT_LEN_W'(k) < len) begin
                ok[k] = fold(window[d[PAT_IDX_W-1:0]], ignore_case) ==
                        fold(pattern[k], ignore_case);
            end else begin
                ok[k] = 1'b1;
            end
        end
    end

    assign hit = (len != '0) && (&ok);

endmodule
`default_nettype wire

[sv/sme_core.sv]
// Processing stage: pattern store, text window and match state, result build.
// Depends on sme_pkg and sme_win_cmp.
`default_nettype none
module sme_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  sme_pkg::in_item_t  item,
    input  sme_pkg::cfg_t      cfg,
    output sme_pkg::out_item_t result
);
    import sme_pkg::*;

    window_t                   pat_reg;
    window_t                   win_reg,  win_next;
    logic [POS_W-1:0]          pos_reg,  pos_next;
    logic                      seen_reg, seen_next;
    logic [TEXT_ADDR_BITS-1:0] first_reg, first_next;
    logic                      prefix_reg, prefix_next;

    logic [PAT_LEN_W-1:0]      len;
    window_t                   win_shift;
    logic [POS_W-1:0]          n_new;
    logic [POS_W-1:0]          s_new;
    logic [POS_W-1:0]          len_w;
    logic [POS_W-1:0]          end_off;
    logic                      hit_shift;
    logic                      hit_cur;
    logic                      text_ok;
    logic                      len_in;

    assign len = (cfg.pattern_length > PAT_LEN_W'(PATTERN_MAX)) ?
                 PAT_LEN_W'(PATTERN_MAX) : cfg.pattern_length;
    assign len_w     = POS_W'(len);
    assign win_shift = {win_reg[PATTERN_MAX-2:0], item.data_byte};
    assign n_new     = pos_reg + POS_W'(1);
    assign s_new     = n_new - len_w;
    assign end_off   = pos_reg - len_w;
    assign text_ok   = !pos_reg[TEXT_ADDR_BITS];
    assign len_in    = (len != '0) && (len_w <= pos_reg);

    sme_win_cmp u_cmp_shift (
        .window      (win_shift),
        .pattern     (pat_reg),
        .len         (len),
        .ignore_case (cfg.ignore_case),
        .hit         (hit_shift)
    );

    sme_win_cmp u_cmp_cur (
        .window      (win_reg),
        .pattern     (pat_reg),
        .len         (len),
        .ignore_case (cfg.ignore_case),
        .hit         (hit_cur)
    );

    always_comb begin
        result = '{status: ST_NOT_FOUND, match_offset: '0, match_length: '0};
        case (cfg.match_mode)
            MODE_FIND: begin
                if (POS_W'(cfg.search_start) >= pos_reg) begin
                    result.status = ST_RANGE;
                end else if (len != '0 && seen_reg) begin
                    result.status       = ST_FOUND;
                    result.match_offset = first_reg;
                end
            end
            MODE_STARTS: begin
                if (len_in && prefix_reg) begin
                    result.status = ST_FOUND;
                end
            end
            MODE_ENDS: begin
                if (len_in && hit_cur) begin
                    result.status       = ST_FOUND;
                    result.match_offset = end_off[TEXT_ADDR_BITS-1:0];
                end
            end
            default: begin
                if (len != '0 && pos_reg == len_w && prefix_reg) begin
                    result.status = ST_FOUND;
                end
            end
        endcase
        if (result.status == ST_FOUND) begin
            result.match_length = len;
        end
    end

    always_comb begin
        win_next    = win_reg;
        pos_next    = pos_reg;
        seen_next   = seen_reg;
        first_next  = first_reg;
        prefix_next = prefix_reg;
        if (fire) begin
            case (item.operation)
                OP_TEXT: begin
                    if (text_ok) begin
                        win_next = win_shift;
                        pos_next = n_new;
                        if (len != '0 && n_new >= len_w) begin
                            if (n_new == len_w) begin
                                prefix_next = hit_shift;
                            end
                            if (hit_shift && !seen_reg &&
                                s_new >= POS_W'(cfg.search_start)) begin
                                seen_next  = 1'b1;
                                first_next = s_new[TEXT_ADDR_BITS-1:0];
                            end
                        end
                    end
                end
                OP_FINISH: begin
                    win_next    = '0;
                    pos_next    = '0;
                    seen_next   = 1'b0;
                    first_next  = '0;
                    prefix_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg    <= '0;
            pos_reg    <= '0;
            seen_reg   <= 1'b0;
            first_reg  <= '0;
            prefix_reg <= 1'b0;
        end else begin
            win_reg    <= win_next;
            pos_reg    <= pos_next;
            seen_reg   <= seen_next;
            first_reg  <= first_next;
            prefix_reg <= prefix_next;
        end
    end

    // pattern store: no reset, unwritten slots are don't-care
    always_ff @(posedge aclk) begin
        if (fire && item.operation == OP_LOAD) begin
            pat_reg[item.pattern_slot] <= item.data_byte;
        end
    end

endmodule
`default_nettype wire
